[hw/rtl/subsampled_block_match_search_assert.svh]
// assertion macros for the block match search
`ifndef SUBSAMPLED_BLOCK_MATCH_SEARCH_ASSERT_SVH
`define SUBSAMPLED_BLOCK_MATCH_SEARCH_ASSERT_SVH
// clocked assertion with asynchronous reset disable
`define SBMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion also checked during reset
`define SBMS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hw/rtl/sbms_pkg.sv]
// package with sizes and codes for the block match search
package sbms_pkg;
  localparam int unsigned FrameSide   = 256;
  localparam int unsigned TerrainSide = 512;
  localparam int unsigned RadiusMax   = 15;
  localparam int unsigned PixelBits   = 32;
  localparam int unsigned SampleStep  = 4;
  localparam int unsigned PctScale    = 100;

  localparam int unsigned FrameAw   = $clog2(FrameSide * FrameSide);
  localparam int unsigned TerrainAw = $clog2(TerrainSide * TerrainSide);
  localparam int unsigned FrameCw   = $clog2(FrameSide);
  localparam int unsigned TerrainCw = $clog2(TerrainSide);

  typedef enum logic [1:0] {
    ModeLoadFrame   = 2'd0,
    ModeLoadTerrain = 2'd1,
    ModeSearch      = 2'd2,
    ModeUnused      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    RegFrameWidth    = 3'd0,
    RegFrameHeight   = 3'd1,
    RegTerrainWidth  = 3'd2,
    RegTerrainHeight = 3'd3,
    RegSearchRadius  = 3'd4
  } reg_idx_e;
endpackage

[hw/rtl/subsampled_block_match_search.sv]
// top level of the subsampled block match search
// a load keeps busy low, so loads can follow each other directly
// a search holds busy for (2r+1)^2 offsets, each read sample by sample, then compared,
//   divided when any sample is inside the terrain, then stepped to the next offset
// a done state follows; the result shows on result_valid_o for one cycle, no stall
// reset restores the register defaults and idles; the pixel rams are not cleared
module subsampled_block_match_search import sbms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [8:0]         pos_x_i,
  input  logic [8:0]         pos_y_i,
  input  logic [31:0]        pixel_value_i,
  input  logic signed [10:0] expected_x_i,
  input  logic signed [10:0] expected_y_i,
  output logic               result_valid_o,
  output logic signed [11:0] best_x_o,
  output logic signed [11:0] best_y_o,
  output logic [6:0]         score_pct_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  typedef enum logic [2:0] {
    StIdle, StRead, StCmp, StDiv, StNext, StDone
  } state_e;

  state_e state_q;
  logic [8:0] fw_q, fh_q;
  logic [9:0] tw_q, th_q;
  logic [3:0] rad_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 9'd240; fh_q <= 9'd160; tw_q <= 10'd512; th_q <= 10'd512; rad_q <= 4'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        RegFrameWidth:    fw_q  <= pwdata[8:0];
        RegFrameHeight:   fh_q  <= pwdata[8:0];
        RegTerrainWidth:  tw_q  <= pwdata[9:0];
        RegTerrainHeight: th_q  <= pwdata[9:0];
        RegSearchRadius:  rad_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      RegFrameWidth:    prdata = {23'd0, fw_q};
      RegFrameHeight:   prdata = {23'd0, fh_q};
      RegTerrainWidth:  prdata = {22'd0, tw_q};
      RegTerrainHeight: prdata = {22'd0, th_q};
      RegSearchRadius:  prdata = {28'd0, rad_q};
      default:          prdata = '0;
    endcase
  end

  // clamped sizes
  logic [8:0] fw_c, fh_c;
  logic [9:0] tw_c, th_c;
  assign fw_c = (fw_q > 9'd256) ? 9'd256 : fw_q;
  assign fh_c = (fh_q > 9'd256) ? 9'd256 : fh_q;
  assign tw_c = (tw_q > 10'd512) ? 10'd512 : tw_q;
  assign th_c = (th_q > 10'd512) ? 10'd512 : th_q;

  // search state
  logic signed [11:0] ex_q, ey_q, bx_q, by_q;
  logic signed [5:0]  dx_q, dy_q;
  logic [5:0]  r_q;
  logic [8:0]  sx_q, sy_q;
  logic [6:0]  bscore_q;
  logic [5:0]  bdist_q;
  logic        bfirst_q;
  logic [14:0] hits_q, count_q;
  logic        cmp_q;

  // sample placement in terrain, scanned one sample per cycle
  logic signed [12:0] tx, ty;
  logic in_terrain, last_sample;
  assign tx = 13'(ex_q) + 13'(dx_q) + 13'(signed'({1'b0, sx_q}));
  assign ty = 13'(ey_q) + 13'(dy_q) + 13'(signed'({1'b0, sy_q}));
  assign in_terrain = (tx >= 0) && (ty >= 0) && (tx < 13'(signed'({1'b0, tw_c})))
                      && (ty < 13'(signed'({1'b0, th_c})));
  assign last_sample = (10'(sx_q) + 10'(SampleStep) >= 10'(fw_c))
                       && (10'(sy_q) + 10'(SampleStep) >= 10'(fh_c));

  // pixel rams
  logic f_we, t_we, accept;
  logic [FrameAw-1:0]   f_addr;
  logic [TerrainAw-1:0] t_addr;
  logic [31:0] f_rd, t_rd;
  assign accept = start && !busy;
  assign f_we = accept && (mode_i == ModeLoadFrame) && (pos_x_i < 9'd256) && (pos_y_i < 9'd256);
  assign t_we = accept && (mode_i == ModeLoadTerrain);
  assign f_addr = (state_q == StIdle) ? {pos_y_i[FrameCw-1:0], pos_x_i[FrameCw-1:0]}
                                      : {sy_q[FrameCw-1:0], sx_q[FrameCw-1:0]};
  assign t_addr = (state_q == StIdle) ? {pos_y_i, pos_x_i}
                                      : {ty[TerrainCw-1:0], tx[TerrainCw-1:0]};

  sbms_ram #(.Width(PixelBits), .Depth(FrameSide * FrameSide)) u_frame (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(pixel_value_i), .rdata_o(f_rd));
  sbms_ram #(.Width(PixelBits), .Depth(TerrainSide * TerrainSide)) u_terrain (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(pixel_value_i), .rdata_o(t_rd));

  // percentage divider
  logic div_start, div_done;
  logic [6:0] pct;
  assign div_start = (state_q == StCmp) && (count_q != '0) && !cmp_q;
  sbms_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(22'(hits_q) * 22'(PctScale)),
    .den_i(count_q), .done_o(div_done), .quot_o(pct));

  logic [5:0] manh_dist;
  assign manh_dist = 6'(dx_q < 0 ? -dx_q : dx_q) + 6'(dy_q < 0 ? -dy_q : dy_q);

  // sequencer: read each sample, compare it once the registered read returns, divide, keep best
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; result_valid_o <= 1'b0; cmp_q <= 1'b0;
      ex_q <= '0; ey_q <= '0; bx_q <= '0; by_q <= '0;
      dx_q <= '0; dy_q <= '0; r_q <= '0; sx_q <= '0; sy_q <= '0;
      bscore_q <= '0; bdist_q <= '0; bfirst_q <= 1'b0; hits_q <= '0; count_q <= '0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        StIdle: if (accept && mode_i == ModeSearch) begin
          ex_q <= 12'(expected_x_i); ey_q <= 12'(expected_y_i);
          bx_q <= 12'(expected_x_i); by_q <= 12'(expected_y_i);
          r_q <= 6'((rad_q > 4'(RadiusMax)) ? 4'(RadiusMax) : rad_q);
          dx_q <= -6'(signed'({2'b0, rad_q})); dy_q <= -6'(signed'({2'b0, rad_q}));
          bscore_q <= '0; bfirst_q <= 1'b1; bdist_q <= '0;
          sx_q <= '0; sy_q <= '0; hits_q <= '0; count_q <= '0; cmp_q <= 1'b0;
          state_q <= StRead;
        end
        StRead: begin
          // an empty frame has no sample at all
          cmp_q <= in_terrain && (fw_c != '0) && (fh_c != '0);
          if (last_sample) state_q <= StCmp;
          if (10'(sx_q) + 10'(SampleStep) >= 10'(fw_c)) begin
            sx_q <= '0; sy_q <= sy_q + 9'(SampleStep);
          end else begin
            sx_q <= sx_q + 9'(SampleStep);
          end
          if (cmp_q) begin
            count_q <= count_q + 15'd1;
            if (f_rd == t_rd) hits_q <= hits_q + 15'd1;
          end
        end
        StCmp: begin
          if (cmp_q) begin
            cmp_q <= 1'b0;
            count_q <= count_q + 15'd1;
            if (f_rd == t_rd) hits_q <= hits_q + 15'd1;
          end else if (count_q == '0) begin
            if (bfirst_q || (bscore_q == '0 && manh_dist < bdist_q)) begin
              bx_q <= ex_q + 12'(dx_q); by_q <= ey_q + 12'(dy_q);
              bdist_q <= manh_dist; bfirst_q <= 1'b0;
            end
            state_q <= StNext;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: if (div_done) begin
          if (bfirst_q || pct > bscore_q || (pct == bscore_q && manh_dist < bdist_q)) begin
            bx_q <= ex_q + 12'(dx_q); by_q <= ey_q + 12'(dy_q);
            bscore_q <= pct; bdist_q <= manh_dist; bfirst_q <= 1'b0;
          end
          state_q <= StNext;
        end
        StNext: begin
          sx_q <= '0; sy_q <= '0; hits_q <= '0; count_q <= '0;
          if (dx_q == signed'(r_q)) begin
            dx_q <= -signed'(r_q);
            if (dy_q == signed'(r_q)) state_q <= StDone;
            else begin dy_q <= dy_q + 6'sd1; state_q <= StRead; end
          end else begin
            dx_q <= dx_q + 6'sd1; state_q <= StRead;
          end
        end
        StDone: begin
          result_valid_o <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy = (state_q != StIdle);
  assign best_x_o = bx_q;
  assign best_y_o = by_q;
  assign score_pct_o = bscore_q;
endmodule

[hw/rtl/sbms_ram.sv]
// generic single port ram with registered read
module sbms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[hw/rtl/sbms_div.sv]
// restoring divider for the percentage, one quotient bit per cycle
module sbms_div import sbms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [21:0] num_i,
  input  logic [14:0] den_i,
  output logic        done_o,
  output logic [6:0]  quot_o
);
  logic [21:0] num_q, num_d;
  logic [15:0] rem_q, rem_d;
  logic [21:0] quo_q, quo_d;
  logic [14:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [15:0] trial;

  // shift in one numerator bit and try to subtract
  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[14:0], num_q[21]};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; quo_d = '0;
      cnt_d = 5'd21; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[20:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[20:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[20:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[6:0];
endmodule

[hw/rtl/sbms_checker.sv]
// port level checker for the block match search, bound to the top level
`include "subsampled_block_match_search_assert.svh"
module sbms_checker import sbms_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] mode_i,
  input logic       result_valid_o,
  input logic [6:0] score_pct_o,
  input logic       pready
);
  `SBMS_ASSERT(a_pct_range, clk_i, rst_ni, result_valid_o |-> score_pct_o <= 7'd100, "pct over 100")
  `SBMS_ASSERT(a_result_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o, "result held")
  `SBMS_ASSERT(a_search_busy, clk_i, rst_ni, (start && !busy && mode_i == ModeSearch) |=> busy, "no busy")
  `SBMS_ASSERT_ALWAYS(a_pready, clk_i, pready, "pready low")
endmodule

bind subsampled_block_match_search sbms_checker u_sbms_checker (.*);

[verif/sbms_placement_checker.sv]
// checker that predicts best placements for the block match search and compares them
module sbms_placement_checker import sbms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [8:0]         pos_x_i,
  input  logic [8:0]         pos_y_i,
  input  logic [31:0]        pixel_value_i,
  input  logic signed [10:0] expected_x_i,
  input  logic signed [10:0] expected_y_i,
  input  logic               result_valid_o,
  input  logic signed [11:0] best_x_o,
  input  logic signed [11:0] best_y_o,
  input  logic [6:0]         score_pct_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [6:0]  pct;
  } placement_t;

  placement_t  placements_due[$];
  bit [31:0]   frame_pix[FrameSide*FrameSide];
  bit [31:0]   terrain_pix[TerrainSide*TerrainSide];
  int unsigned frame_w, frame_h, terrain_w, terrain_h, radius;
  int          fails;

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  // truncated percentage of equal samples for one placement
  function automatic int unsigned match_score(int px, int py);
    int unsigned hits, count, fw, fh;
    int tw, th, tx, ty;
    hits = 0;
    count = 0;
    fw = clip(frame_w, FrameSide);
    fh = clip(frame_h, FrameSide);
    tw = int'(clip(terrain_w, TerrainSide));
    th = int'(clip(terrain_h, TerrainSide));
    for (int unsigned y = 0; y < fh; y += SampleStep) begin
      ty = py + int'(y);
      if (ty < 0 || ty >= th) continue;
      for (int unsigned x = 0; x < fw; x += SampleStep) begin
        tx = px + int'(x);
        if (tx < 0 || tx >= tw) continue;
        if (frame_pix[y*FrameSide + x] == terrain_pix[ty*TerrainSide + tx]) hits++;
        count++;
      end
    end
    return (count != 0) ? hits * PctScale / count : 0;
  endfunction

  // full search over the radius, highest score then nearest then first scanned
  function automatic placement_t best_placement(int ex, int ey);
    placement_t  best;
    int          r, bx, by, bdist, d;
    int unsigned bscore, s;
    r = int'(clip(radius, RadiusMax));
    bx = ex;
    by = ey;
    bscore = 0;
    bdist = 32'h7fff_ffff;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        s = match_score(ex + dx, ey + dy);
        d = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        if (s > bscore || (s == bscore && d < bdist)) begin
          bx = ex + dx;
          by = ey + dy;
          bscore = s;
          bdist = d;
        end
      end
    end
    best.x = bx[11:0];
    best.y = by[11:0];
    best.pct = bscore[6:0];
    return best;
  endfunction

  // watch register writes, input words and result words
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t got, due;
    if (!rst_ni) begin
      frame_w = 240;
      frame_h = 160;
      terrain_w = 512;
      terrain_h = 512;
      radius = 4;
      placements_due.delete();
      pending_o <= 0;
      fail_count_o <= fails;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          RegFrameWidth:    frame_w = pwdata[8:0];
          RegFrameHeight:   frame_h = pwdata[8:0];
          RegTerrainWidth:  terrain_w = pwdata[9:0];
          RegTerrainHeight: terrain_h = pwdata[9:0];
          RegSearchRadius:  radius = pwdata[3:0];
          default: ;
        endcase
      end
      if (result_valid_o) begin
        got = '{best_x_o, best_y_o, score_pct_o};
        if (placements_due.size() == 0) begin
          $error("result word with no search waiting");
          fails++;
        end else begin
          due = placements_due.pop_front();
          if (got.x !== due.x) begin
            $error("best_x expected %0d got %0d", $signed(due.x), $signed(got.x));
            fails++;
          end
          if (got.y !== due.y) begin
            $error("best_y expected %0d got %0d", $signed(due.y), $signed(got.y));
            fails++;
          end
          if (got.pct !== due.pct) begin
            $error("score_pct expected %0d got %0d", due.pct, got.pct);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        case (mode_e'(mode_i))
          ModeLoadFrame:
            if (pos_x_i < FrameSide && pos_y_i < FrameSide)
              frame_pix[pos_y_i*FrameSide + pos_x_i] = pixel_value_i;
          ModeLoadTerrain:
            terrain_pix[pos_y_i*TerrainSide + pos_x_i] = pixel_value_i;
          ModeSearch:
            placements_due.push_back(best_placement(int'(expected_x_i), int'(expected_y_i)));
          default: ;
        endcase
      end
      pending_o <= placements_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

[verif/subsampled_block_match_search_test.sv]
// stimulus and verdict for the subsampled block match search
module subsampled_block_match_search_test;
  import sbms_pkg::*;

  localparam int IdleLimit = 300000;

  logic               clk_i, rst_ni, start, busy;
  logic [1:0]         mode_i;
  logic [8:0]         pos_x_i, pos_y_i;
  logic [31:0]        pixel_value_i;
  logic signed [10:0] expected_x_i, expected_y_i;
  logic               result_valid_o;
  logic signed [11:0] best_x_o, best_y_o;
  logic [6:0]         score_pct_o;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 fail_count, pending;

  // mirror of what has been loaded, so no unwritten pixel is ever compared
  bit [31:0]   frame_copy[FrameSide*FrameSide];
  bit          frame_set[FrameSide*FrameSide];
  bit          terrain_set[TerrainSide*TerrainSide];
  int unsigned cfg[5];
  int          words_sent, searches_sent, idle_cycles;
  bit          gaps_on;

  subsampled_block_match_search i_dut (.*);

  sbms_placement_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .pos_x_i, .pos_y_i, .pixel_value_i,
    .expected_x_i, .expected_y_i, .result_valid_o, .best_x_o, .best_y_o,
    .score_pct_o, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog on cycles without any accepted word or result
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(mode_e m, int x, int y, bit [31:0] v, int ex, int ey);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    start = 1'b1;
    mode_i = m;
    pos_x_i = x[8:0];
    pos_y_i = y[8:0];
    pixel_value_i = v;
    expected_x_i = ex[10:0];
    expected_y_i = ey[10:0];
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (m == ModeSearch) searches_sent++;
    if (m == ModeSearch || m == ModeLoadTerrain ||
        (m == ModeLoadFrame && x < FrameSide && y < FrameSide)) words_sent++;
  endtask

  task automatic put_pixel(mode_e m, int x, int y, bit [31:0] v);
    send_word(m, x, y, v, $urandom, $urandom);
    if (m == ModeLoadTerrain) terrain_set[y*TerrainSide + x] = 1'b1;
    else if (x < FrameSide && y < FrameSide) begin
      frame_set[y*FrameSide + x] = 1'b1;
      frame_copy[y*FrameSide + x] = v;
    end
  endtask

  function automatic bit [31:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h0;
      2: return 32'hffff_ffff;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // hold off until every expected result has come and the block is idle
  task automatic drain();
    start = 1'b0;
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned v);
    cfg[idx] = v;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 5'(idx) << 2;
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_sizes(int unsigned fw, int unsigned fh, int unsigned tw,
                           int unsigned th, int unsigned r);
    drain();
    write_reg(RegFrameWidth, fw);
    write_reg(RegFrameHeight, fh);
    write_reg(RegTerrainWidth, tw);
    write_reg(RegTerrainHeight, th);
    write_reg(RegSearchRadius, r);
  endtask

  // load frame samples, plant them near the expected spot, fill the rest, then search
  task automatic search_at(int ex, int ey, int noise);
    int r, tdx, tdy, tx, ty, fw, fh, tw, th;
    fw = cfg[RegFrameWidth];
    fh = cfg[RegFrameHeight];
    tw = cfg[RegTerrainWidth];
    th = cfg[RegTerrainHeight];
    r = cfg[RegSearchRadius];
    for (int y = 0; y < fh; y += SampleStep)
      for (int x = 0; x < fw; x += SampleStep)
        if (!frame_set[y*FrameSide + x]) put_pixel(ModeLoadFrame, x, y, pick_pixel());
    tdx = $urandom_range(0, 2*r) - r;
    tdy = $urandom_range(0, 2*r) - r;
    for (int y = 0; y < fh; y += SampleStep)
      for (int x = 0; x < fw; x += SampleStep) begin
        tx = ex + tdx + x;
        ty = ey + tdy + y;
        if (tx >= 0 && tx < tw && ty >= 0 && ty < th && $urandom_range(0, 3) != 0)
          put_pixel(ModeLoadTerrain, tx, ty, frame_copy[y*FrameSide + x]);
      end
    for (int dy = -r; dy <= r; dy++)
      for (int dx = -r; dx <= r; dx++)
        for (int y = 0; y < fh; y += SampleStep)
          for (int x = 0; x < fw; x += SampleStep) begin
            tx = ex + dx + x;
            ty = ey + dy + y;
            if (tx >= 0 && tx < tw && ty >= 0 && ty < th && !terrain_set[ty*TerrainSide + tx])
              put_pixel(ModeLoadTerrain, tx, ty, pick_pixel());
          end
    // noise: stray loads, ignored loads and the unused mode
    repeat (noise) begin
      case ($urandom_range(0, 3))
        0: send_word(ModeUnused, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: put_pixel(ModeLoadFrame, $urandom_range(0, 511), $urandom_range(0, 511),
                     pick_pixel());
        default: put_pixel(ModeLoadTerrain, $urandom_range(0, tw - 1),
                           $urandom_range(0, th - 1), pick_pixel());
      endcase
    end
    send_word(ModeSearch, 0, 0, $urandom, ex, ey);
  endtask

  initial begin
    int fw, fh, tw, th, r, ex, ey;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = ModeLoadFrame;
    pos_x_i = '0;
    pos_y_i = '0;
    pixel_value_i = '0;
    expected_x_i = '0;
    expected_y_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    words_sent = 0;
    searches_sent = 0;
    gaps_on = 1'b1;
    cfg = '{240, 160, 512, 512, 4};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every mode, ignored loads, searches off the terrain
    set_sizes(8, 8, 16, 16, 0);
    put_pixel(ModeLoadFrame, 0, 0, 32'h0);
    put_pixel(ModeLoadFrame, 255, 255, 32'hffff_ffff);
    put_pixel(ModeLoadFrame, 300, 511, 32'h1234_5678);
    put_pixel(ModeLoadTerrain, 511, 511, 32'hffff_ffff);
    put_pixel(ModeLoadTerrain, 0, 0, 32'h0);
    send_word(ModeUnused, 511, 511, 32'hffff_ffff, -1, -1);
    send_word(ModeSearch, 0, 0, 32'h0, -1024, -1024);
    send_word(ModeSearch, 511, 511, 32'h0, 1023, 1023);
    search_at(0, 0, 2);
    search_at(10, -5, 1);
    set_sizes(1, 1, 512, 512, 15);
    search_at(0, 0, 0);
    search_at(500, 505, 1);
    set_sizes(256, 4, 512, 512, 0);
    search_at(256, 256, 0);
    set_sizes(5, 5, 1, 1, 2);
    search_at(0, 0, 1);
    search_at(-3, 2, 0);

    // random phases with small sizes so that searches stay short
    while (words_sent < 1750 || searches_sent < 60) begin
      if (words_sent > 1400 && searches_sent > 45) gaps_on = 1'b0;
      fw = $urandom_range(1, 20);
      fh = $urandom_range(1, 20);
      tw = $urandom_range(1, 24);
      th = $urandom_range(1, 24);
      r = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(0, 2);
      set_sizes(fw, fh, tw, th, r);
      repeat ($urandom_range(4, 8)) begin
        if ($urandom_range(0, 7) == 0) begin
          ex = $urandom_range(0, 2047) - 1024;
          ey = $urandom_range(0, 2047) - 1024;
        end else begin
          ex = $urandom_range(0, tw + fw) - fw;
          ey = $urandom_range(0, th + fh) - fh;
        end
        search_at(ex, ey, $urandom_range(0, 6));
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
